// ===== design/otp_fuse_program_controller_top_defines.svh =====
// ----------------------------------------------------------------------------
// otp fuse program controller assertion macros
// shared concurrent assertion forms, clocked on clk_i and held off in reset
// ----------------------------------------------------------------------------
`ifndef OTP_FUSE_PROGRAM_CONTROLLER_TOP_DEFINES_SVH
`define OTP_FUSE_PROGRAM_CONTROLLER_TOP_DEFINES_SVH

// property must hold at every clock edge outside reset
`define OFPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition must never be seen outside reset
`define OFPC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== design/ofpc_pkg.sv =====
// ----------------------------------------------------------------------------
// ofpc_pkg
// shared types, codes and constants of the otp fuse program controller
// ----------------------------------------------------------------------------
package ofpc_pkg;

  localparam int FUSE_COUNT_DEF      = 4096;
  localparam int LOCK_FUSE_INDEX_DEF = 993;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEST_MODE     = 2'd1;

  localparam logic [15:0] PROGRAM_TICKS_RST = 16'd100;

  localparam logic [7:0] ADDR_CONTROL = 8'd128;
  localparam logic [7:0] ADDR_BIT     = 8'd129;
  localparam logic [7:0] ADDR_PERFORM = 8'd130;
  localparam logic [7:0] ADDR_PAD_EN  = 8'd131;
  localparam logic [7:0] ADDR_PAD     = 8'd132;

  localparam logic [31:0] MAGIC_PERFORM = 32'h6675_7365;
  localparam logic [31:0] MAGIC_PAD_EN  = 32'h656e_626c;
  localparam logic [31:0] MAGIC_PAD     = 32'h5644_4451;

  localparam logic [12:0] TARGET_MAX = 13'h1FFF;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD     = 2'd1,
    ST_REFUSED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MOP_READ = 2'd0,
    MOP_OR   = 2'd1,
    MOP_SET  = 2'd2
  } mem_op_e;

  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_MEM  = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic load_direct;
    logic mem_commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic needs_mem;
  } dp_status_t;

endpackage

// ===== design/ofpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ofpc_ctrl
// transfer sequencing: direct register accesses and two-phase fuse word access
// ----------------------------------------------------------------------------
module ofpc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  ofpc_pkg::dp_status_t  status_i,
  output ofpc_pkg::ctrl_cmd_t   cmd_o
);

  ofpc_pkg::ctrl_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic                  accept;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ofpc_pkg::CS_IDLE: begin
        if (accept && status_i.needs_mem) state_d = ofpc_pkg::CS_MEM;
      end
      ofpc_pkg::CS_MEM: begin
        state_d = ofpc_pkg::CS_IDLE;
      end
      default: state_d = ofpc_pkg::CS_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o        = 1'b0;
    cmd_o.accept      = 1'b0;
    cmd_o.load_direct = 1'b0;
    cmd_o.mem_commit  = 1'b0;
    unique case (state_q)
      ofpc_pkg::CS_IDLE: begin
        in_ready_o        = !out_valid_q || out_ready_i;
        cmd_o.accept      = accept;
        cmd_o.load_direct = accept && !status_i.needs_mem;
      end
      ofpc_pkg::CS_MEM: begin
        cmd_o.mem_commit = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cmd_o.load_direct || cmd_o.mem_commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ofpc_pkg::CS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`include "otp_fuse_program_controller_top_defines.svh"

  `OFPC_ASSERT(a_mem_enter, (cmd_o.accept && status_i.needs_mem) |=> (state_q == ofpc_pkg::CS_MEM), "fuse word access did not enter memory phase")
  `OFPC_ASSERT(a_mem_leave, (state_q == ofpc_pkg::CS_MEM) |=> ((state_q == ofpc_pkg::CS_IDLE) && out_valid_q), "memory phase did not deliver a result")
  `OFPC_ASSERT_NEVER(a_mem_out_free, (state_q == ofpc_pkg::CS_MEM) && out_valid_q, "output register occupied during memory phase")

endmodule

// ===== design/ofpc_datapath.sv =====
// ----------------------------------------------------------------------------
// ofpc_datapath
// fuse word memory, control registers, programming timer and result register
// ----------------------------------------------------------------------------
module ofpc_datapath #(
  parameter int FUSE_COUNT      = ofpc_pkg::FUSE_COUNT_DEF,
  parameter int LOCK_FUSE_INDEX = ofpc_pkg::LOCK_FUSE_INDEX_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ofpc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ofpc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [1:0]                          in_cmd_i,
  input  logic [7:0]                          in_addr_i,
  input  logic [31:0]                         in_data_i,
  input  ofpc_pkg::ctrl_cmd_t                 ctrl_i,
  output ofpc_pkg::dp_status_t                status_o,
  output logic [31:0]                         read_data_o,
  output logic [1:0]                          access_status_o,
  output logic                                busy_res_o
);

  localparam int FUSE_WORDS = (FUSE_COUNT + 31) / 32;
  localparam int MEM_WORDS  = (FUSE_WORDS < 256) ? FUSE_WORDS : 256;
  localparam int BUS_LIMIT  = (FUSE_WORDS < 128) ? FUSE_WORDS : 128;
  localparam int MEM_AW     = $clog2(MEM_WORDS);
  localparam int LOCK_WORD  = LOCK_FUSE_INDEX / 32;
  localparam int LOCK_BIT   = LOCK_FUSE_INDEX % 32;
  localparam bit LOCK_IN    = LOCK_WORD < FUSE_WORDS;

  // configuration
  logic [15:0] program_ticks_q;
  logic        test_mode_q;

  // control state
  logic [12:0] target_q, target_d;
  logic        pad_en_q, pad_en_d;
  logic        pad_q, pad_d;
  logic        busy_q, busy_d;
  logic [15:0] ticks_q, ticks_d;
  logic        lock_q;
  logic [MEM_WORDS-1:0] valid_q;

  // fuse word memory and pending access
  logic [31:0]             mem [MEM_WORDS];
  logic [31:0]             rd_word_q;
  logic                    rd_vld_q;
  ofpc_pkg::mem_op_e       op_q, mop;
  logic [31:0]             op_data_q;
  logic [MEM_AW-1:0]       op_addr_q, mem_idx;

  // result register
  logic [31:0]             rd_out_q;
  ofpc_pkg::status_e       st_out_q;
  logic                    busy_out_q;

  logic                    needs_mem;
  logic [31:0]             dir_rd;
  ofpc_pkg::status_e       dir_st;
  logic                    bus_word;
  logic                    target_ok;
  logic [31:0]             word_now;
  logic [31:0]             cm_wdata;
  logic [31:0]             cm_rd;
  logic                    cm_we;
  logic                    cm_lock;

  assign bus_word  = {1'b0, in_addr_i} < 9'(BUS_LIMIT);
  assign target_ok = {4'b0, target_q} < 17'(FUSE_COUNT);

  // decode of the incoming item
  always_comb begin
    needs_mem = 1'b0;
    mop       = ofpc_pkg::MOP_READ;
    mem_idx   = in_addr_i[MEM_AW-1:0];
    dir_rd    = '0;
    dir_st    = ofpc_pkg::ST_OK;
    target_d  = target_q;
    pad_en_d  = pad_en_q;
    pad_d     = pad_q;
    busy_d    = busy_q;
    ticks_d   = ticks_q;
    unique case (ofpc_pkg::cmd_e'(in_cmd_i))
      ofpc_pkg::CMD_TICK: begin
        if (busy_q) begin
          if (ticks_q > 16'd1) begin
            ticks_d = ticks_q - 16'd1;
          end else begin
            needs_mem = 1'b1;
            mop       = ofpc_pkg::MOP_SET;
            mem_idx   = target_q[MEM_AW+4:5];
          end
        end
      end
      ofpc_pkg::CMD_READ: begin
        if (!in_addr_i[7]) begin
          if (bus_word) needs_mem = 1'b1;
          else          dir_st    = ofpc_pkg::ST_BAD;
        end else if (in_addr_i == ofpc_pkg::ADDR_CONTROL) begin
          dir_rd = {29'b0, pad_q, pad_en_q, busy_q};
        end else if (in_addr_i == ofpc_pkg::ADDR_BIT) begin
          dir_rd = {19'b0, target_q};
        end else begin
          dir_st = ofpc_pkg::ST_BAD;
        end
      end
      ofpc_pkg::CMD_WRITE: begin
        if (!in_addr_i[7]) begin
          if (bus_word && test_mode_q) begin
            needs_mem = 1'b1;
            mop       = ofpc_pkg::MOP_OR;
          end else begin
            dir_st = ofpc_pkg::ST_BAD;
          end
        end else if (in_addr_i == ofpc_pkg::ADDR_BIT) begin
          if (busy_q) begin
            dir_st = ofpc_pkg::ST_REFUSED;
          end else if (in_data_i > {19'b0, ofpc_pkg::TARGET_MAX}) begin
            target_d = ofpc_pkg::TARGET_MAX;
          end else begin
            target_d = in_data_i[12:0];
          end
        end else if (in_addr_i == ofpc_pkg::ADDR_PERFORM) begin
          if (in_data_i == ofpc_pkg::MAGIC_PERFORM) begin
            if (busy_q || !pad_en_q || !pad_q || !target_ok || lock_q) begin
              dir_st = ofpc_pkg::ST_REFUSED;
            end else begin
              busy_d  = 1'b1;
              ticks_d = (program_ticks_q == '0) ? 16'd1 : program_ticks_q;
            end
          end
        end else if (in_addr_i == ofpc_pkg::ADDR_PAD_EN) begin
          pad_en_d = in_data_i == ofpc_pkg::MAGIC_PAD_EN;
        end else if (in_addr_i == ofpc_pkg::ADDR_PAD) begin
          pad_d = in_data_i == ofpc_pkg::MAGIC_PAD;
        end else begin
          dir_st = ofpc_pkg::ST_BAD;
        end
      end
      default: dir_st = ofpc_pkg::ST_BAD;
    endcase
  end

  assign status_o.needs_mem = needs_mem;

  // second phase of a fuse word access
  assign word_now = rd_vld_q ? rd_word_q : '0;

  always_comb begin
    cm_rd    = '0;
    cm_we    = 1'b0;
    cm_wdata = word_now;
    cm_lock  = 1'b0;
    unique case (op_q)
      ofpc_pkg::MOP_READ: begin
        cm_rd = word_now;
      end
      ofpc_pkg::MOP_OR: begin
        cm_we    = 1'b1;
        cm_wdata = word_now | op_data_q;
        cm_lock  = LOCK_IN && (op_addr_q == MEM_AW'(LOCK_WORD)) && op_data_q[LOCK_BIT];
      end
      ofpc_pkg::MOP_SET: begin
        cm_we    = 1'b1;
        cm_wdata = word_now | (32'd1 << target_q[4:0]);
        cm_lock  = LOCK_IN && (target_q == 13'(LOCK_FUSE_INDEX));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mem_commit && cm_we) begin
      mem[op_addr_q] <= cm_wdata;
    end
    if (ctrl_i.accept) begin
      rd_word_q <= mem[mem_idx];
      rd_vld_q  <= valid_q[mem_idx];
      op_q      <= mop;
      op_addr_q <= mem_idx;
      op_data_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_direct) begin
      rd_out_q   <= dir_rd;
      st_out_q   <= dir_st;
      busy_out_q <= busy_d;
    end else if (ctrl_i.mem_commit) begin
      rd_out_q   <= cm_rd;
      st_out_q   <= ofpc_pkg::ST_OK;
      busy_out_q <= (op_q == ofpc_pkg::MOP_SET) ? 1'b0 : busy_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      program_ticks_q <= ofpc_pkg::PROGRAM_TICKS_RST;
      test_mode_q     <= 1'b0;
      target_q        <= '0;
      pad_en_q        <= 1'b0;
      pad_q           <= 1'b0;
      busy_q          <= 1'b0;
      ticks_q         <= '0;
      lock_q          <= 1'b0;
      valid_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          ofpc_pkg::CFG_PROGRAM_TICKS: program_ticks_q <= cfg_data_i;
          ofpc_pkg::CFG_TEST_MODE:     test_mode_q     <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (ctrl_i.load_direct) begin
        target_q <= target_d;
        pad_en_q <= pad_en_d;
        pad_q    <= pad_d;
        busy_q   <= busy_d;
        ticks_q  <= ticks_d;
      end
      if (ctrl_i.mem_commit) begin
        if (cm_we) valid_q[op_addr_q] <= 1'b1;
        if (cm_lock) lock_q <= 1'b1;
        if (op_q == ofpc_pkg::MOP_SET) begin
          busy_q  <= 1'b0;
          ticks_q <= '0;
        end
      end
    end
  end

  assign read_data_o     = rd_out_q;
  assign access_status_o = st_out_q;
  assign busy_res_o      = busy_out_q;

`include "otp_fuse_program_controller_top_defines.svh"

  `OFPC_ASSERT(a_busy_has_ticks, busy_q |-> (ticks_q != '0), "busy with no ticks left")
  `OFPC_ASSERT(a_busy_clears_on_set, $fell(busy_q) |-> $past(ctrl_i.mem_commit && (op_q == ofpc_pkg::MOP_SET)), "busy cleared without fuse set")
  `OFPC_ASSERT_NEVER(a_set_when_idle, ctrl_i.accept && (mop == ofpc_pkg::MOP_SET) && needs_mem && !busy_q, "fuse set started while idle")

endmodule

// ===== design/otp_fuse_program_controller_top.sv =====
// ----------------------------------------------------------------------------
// otp_fuse_program_controller_top
// one-time-programmable fuse array controller with register bus and tick input
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one bus read, bus write or time tick per transfer; the
//   command sits in tuser, address and write data in tdata.
//   m_axis returns exactly one result per input transfer, in order.
//   cfg_* writes program_ticks (index 0) and test_mode (index 1); it is always
//   ready and must only be used while the block is idle.
// result path:
//   control register accesses, ticks that do not end a programming run and
//   unmapped accesses: result valid the cycle after the transfer, one per cycle
//   while m_axis_tready is high. fuse word reads, test-mode fuse word writes and
//   the final tick of a programming run pass the registered read port of the
//   fuse word memory, then the output register; no transfer is taken meanwhile.
// reset:
//   all control registers clear and every fuse word reads as zero at once;
//   there is no clearing pass.
// stall:
//   a result waits in the output register while m_axis_tready is low; a new
//   transfer is taken only in the cycle that register frees up.
// ----------------------------------------------------------------------------
module otp_fuse_program_controller_top #(
  parameter int FUSE_COUNT      = ofpc_pkg::FUSE_COUNT_DEF,
  parameter int LOCK_FUSE_INDEX = ofpc_pkg::LOCK_FUSE_INDEX_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [39:0]                        s_axis_tdata,  // word_address, write_data
  input  logic [1:0]                         s_axis_tuser,  // command
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [39:0]                        m_axis_tdata,  // read_data, access_status, busy_res
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ofpc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ofpc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  ofpc_pkg::ctrl_cmd_t  ctrl_cmd;
  ofpc_pkg::dp_status_t dp_status;
  logic [31:0]          read_data;
  logic [1:0]           access_status;
  logic                 busy_res;

  assign cfg_ready_o = 1'b1;

  ofpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (dp_status),
    .cmd_o       (ctrl_cmd)
  );

  ofpc_datapath #(
    .FUSE_COUNT      (FUSE_COUNT),
    .LOCK_FUSE_INDEX (LOCK_FUSE_INDEX)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_cmd_i        (s_axis_tuser),
    .in_addr_i       (s_axis_tdata[7:0]),
    .in_data_i       (s_axis_tdata[39:8]),
    .ctrl_i          (ctrl_cmd),
    .status_o        (dp_status),
    .read_data_o     (read_data),
    .access_status_o (access_status),
    .busy_res_o      (busy_res)
  );

  assign m_axis_tdata = {5'b0, busy_res, access_status, read_data};

endmodule

// ===== test/otp_fuse_program_controller_top_test.sv =====
// ----------------------------------------------------------------------------
// otp_fuse_program_controller_top_test
// drives bus reads, bus writes and ticks into the fuse controller under several
// register settings and idle patterns, predicts every result in a scoreboard
// and compares each returned transfer field by field
// ----------------------------------------------------------------------------
module otp_fuse_program_controller_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          FUSE_BITS      = ofpc_pkg::FUSE_COUNT_DEF;
  localparam int          LOCK_BIT       = ofpc_pkg::LOCK_FUSE_INDEX_DEF;
  localparam logic [7:0]  LOCK_WORD      = 8'(LOCK_BIT / 32);
  localparam logic [7:0]  LAST_WORD      = 8'd127;
  localparam logic [7:0]  ADDR_UNMAPPED  = 8'd255;
  localparam logic [1:0]  CMD_UNUSED     = 2'd3;
  localparam int          LONG_TICKS     = 120;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          MAX_PRINTS     = 40;

  typedef struct packed {
    logic [31:0]       read_data;
    ofpc_pkg::status_e status;
    logic              busy;
  } fuse_result_t;

  class fuse_scoreboard;
    logic [31:0]  fuse_mem [128];
    logic [12:0]  target;
    bit           pad_en_ok;
    bit           pad_ok;
    bit           busy;
    logic [15:0]  ticks_left;
    logic [15:0]  prog_ticks;
    bit           test_mode;
    fuse_result_t results_q [$];
    int           mismatches;
    int           checked;

    function new();
      foreach (fuse_mem[i]) fuse_mem[i] = '0;
      target     = '0;
      pad_en_ok  = 1'b0;
      pad_ok     = 1'b0;
      busy       = 1'b0;
      ticks_left = '0;
      prog_ticks = ofpc_pkg::PROGRAM_TICKS_RST;
      test_mode  = 1'b0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void set_register(logic [ofpc_pkg::CFG_IDX_W-1:0] idx,
                               logic [ofpc_pkg::CFG_DATA_W-1:0] value);
      if (idx == ofpc_pkg::CFG_PROGRAM_TICKS) begin
        prog_ticks = value;
      end else if (idx == ofpc_pkg::CFG_TEST_MODE) begin
        test_mode = value[0];
      end
    endfunction

    function bit lock_blown();
      return fuse_mem[LOCK_WORD][LOCK_BIT % 32];
    endfunction

    function int pending();
      return results_q.size();
    endfunction

    function void note_access(logic [1:0] cmd, logic [7:0] addr, logic [31:0] data);
      fuse_result_t r;
      r.read_data = '0;
      r.status    = ofpc_pkg::ST_OK;
      case (cmd)
        ofpc_pkg::CMD_TICK: begin
          if (busy) begin
            if (ticks_left != 0) ticks_left--;
            if (ticks_left == 0) begin
              if (target < FUSE_BITS) fuse_mem[target[11:5]][target[4:0]] = 1'b1;
              busy = 1'b0;
            end
          end
        end
        ofpc_pkg::CMD_READ: begin
          if (addr < 8'd128) begin
            r.read_data = fuse_mem[addr[6:0]];
          end else if (addr == ofpc_pkg::ADDR_CONTROL) begin
            r.read_data = {29'b0, pad_ok, pad_en_ok, busy};
          end else if (addr == ofpc_pkg::ADDR_BIT) begin
            r.read_data = {19'b0, target};
          end else begin
            r.status = ofpc_pkg::ST_BAD;
          end
        end
        ofpc_pkg::CMD_WRITE: begin
          if (addr < 8'd128) begin
            if (test_mode) fuse_mem[addr[6:0]] |= data;
            else r.status = ofpc_pkg::ST_BAD;
          end else if (addr == ofpc_pkg::ADDR_BIT) begin
            if (busy) begin
              r.status = ofpc_pkg::ST_REFUSED;
            end else begin
              target = (data > {19'b0, ofpc_pkg::TARGET_MAX}) ? ofpc_pkg::TARGET_MAX
                                                              : data[12:0];
            end
          end else if (addr == ofpc_pkg::ADDR_PERFORM) begin
            if (data == ofpc_pkg::MAGIC_PERFORM) begin
              if (busy || !pad_en_ok || !pad_ok || target >= FUSE_BITS || lock_blown()) begin
                r.status = ofpc_pkg::ST_REFUSED;
              end else begin
                busy       = 1'b1;
                ticks_left = (prog_ticks == 0) ? 16'd1 : prog_ticks;
              end
            end
          end else if (addr == ofpc_pkg::ADDR_PAD_EN) begin
            pad_en_ok = (data == ofpc_pkg::MAGIC_PAD_EN);
          end else if (addr == ofpc_pkg::ADDR_PAD) begin
            pad_ok = (data == ofpc_pkg::MAGIC_PAD);
          end else begin
            r.status = ofpc_pkg::ST_BAD;
          end
        end
        default: begin
          r.status = ofpc_pkg::ST_BAD;
        end
      endcase
      r.busy = busy;
      results_q.push_back(r);
    endfunction

    task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      if (mismatches < MAX_PRINTS) begin
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, field, got, want);
      end
      mismatches++;
    endtask

    task check_result(logic [31:0] read_data, logic [1:0] status, logic busy_res);
      fuse_result_t want;
      if (results_q.size() == 0) begin
        report_mismatch("result with nothing outstanding", read_data, '0);
      end else begin
        want = results_q.pop_front();
        checked++;
        if (read_data !== want.read_data) report_mismatch("read_data", read_data, want.read_data);
        if (status !== want.status) report_mismatch("access_status", status, want.status);
        if (busy_res !== want.busy) report_mismatch("busy_res", busy_res, want.busy);
      end
    endtask
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [39:0]                     s_axis_tdata;   // word_address, write_data
  logic [1:0]                      s_axis_tuser;   // command
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [39:0]                     m_axis_tdata;   // read_data, access_status, busy_res
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [ofpc_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [ofpc_pkg::CFG_DATA_W-1:0] cfg_data_i;

  fuse_scoreboard sb;
  int             send_idle_pct;
  int             recv_stall_pct;
  bit             allow_lock;
  int             items_sent;
  int             phases;
  int             quiet_cycles;

  otp_fuse_program_controller_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic send_access(input logic [1:0] cmd, input logic [7:0] addr,
                             input logic [31:0] data);
    logic [31:0] wdata;
    wdata = data;
    // keep the lock fuse intact until the lock phase
    if (!allow_lock && cmd == ofpc_pkg::CMD_WRITE) begin
      if (addr == LOCK_WORD) wdata[LOCK_BIT % 32] = 1'b0;
      if (addr == ofpc_pkg::ADDR_BIT && wdata == LOCK_BIT) wdata = 32'(LOCK_BIT + 1);
    end
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {wdata, addr};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_access(cmd, addr, wdata);
    items_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [ofpc_pkg::CFG_IDX_W-1:0] idx,
                                input logic [ofpc_pkg::CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_register(idx, value);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic start_phase(input logic [15:0] ticks, input logic tmode, input int mode);
    wait_drained();
    write_register(ofpc_pkg::CFG_PROGRAM_TICKS, ticks);
    write_register(ofpc_pkg::CFG_TEST_MODE, {15'b0, tmode});
    send_idle_pct  = (mode == 1) ? 88 : (mode == 3) ? 29 : 0;
    recv_stall_pct = (mode == 2) ? 88 : (mode == 3) ? 29 : 0;
    phases++;
  endtask

  task automatic settle_busy();
    while (sb.busy) send_access(ofpc_pkg::CMD_TICK, '0, $urandom);
  endtask

  task automatic arm_pads(input bit clean);
    send_access(ofpc_pkg::CMD_WRITE, ofpc_pkg::ADDR_PAD_EN,
                (clean || $urandom_range(9) != 0) ? ofpc_pkg::MAGIC_PAD_EN : $urandom);
    send_access(ofpc_pkg::CMD_WRITE, ofpc_pkg::ADDR_PAD,
                (clean || $urandom_range(9) != 0) ? ofpc_pkg::MAGIC_PAD : $urandom);
  endtask

  task automatic run_program_sequence();
    logic [31:0] bit_addr;
    int          n;
    case ($urandom_range(9))
      0:       bit_addr = $urandom;
      1:       bit_addr = $urandom_range(8191, FUSE_BITS);
      default: bit_addr = $urandom_range(FUSE_BITS - 1, 0);
    endcase
    send_access(ofpc_pkg::CMD_WRITE, ofpc_pkg::ADDR_BIT, bit_addr);
    arm_pads(1'b0);
    if ($urandom_range(3) == 0) send_access(ofpc_pkg::CMD_READ, ofpc_pkg::ADDR_CONTROL, $urandom);
    send_access(ofpc_pkg::CMD_WRITE, ofpc_pkg::ADDR_PERFORM,
                ($urandom_range(7) != 0) ? ofpc_pkg::MAGIC_PERFORM : $urandom);
    n = ((sb.prog_ticks == 0) ? 1 : sb.prog_ticks) + $urandom_range(2);
    if ($urandom_range(4) == 0) n = $urandom_range(n);
    for (int i = 0; i < n; i++) begin
      send_access(ofpc_pkg::CMD_TICK, $urandom, $urandom);
      if ($urandom_range(5) == 0) begin
        send_access(ofpc_pkg::CMD_READ, ofpc_pkg::ADDR_CONTROL, $urandom);
      end
    end
    send_access(ofpc_pkg::CMD_READ, {1'b0, bit_addr[11:5]}, $urandom);
  endtask

  task automatic send_noise();
    logic [1:0]  cmd;
    logic [7:0]  addr;
    logic [31:0] data;
    cmd  = ($urandom_range(19) == 0) ? CMD_UNUSED : 2'($urandom_range(2));
    addr = ($urandom_range(5) == 0) ? 8'($urandom_range(255))
                                    : 8'($urandom_range(ofpc_pkg::ADDR_PAD));
    case ($urandom_range(5))
      0:       data = ofpc_pkg::MAGIC_PERFORM;
      1:       data = ofpc_pkg::MAGIC_PAD_EN;
      2:       data = ofpc_pkg::MAGIC_PAD;
      3:       data = $urandom & $urandom & $urandom;
      default: data = $urandom;
    endcase
    send_access(cmd, addr, data);
  endtask

  // result side: random stall and checking
  initial begin
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata[31:0], m_axis_tdata[33:32], m_axis_tdata[34]);
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    quiet_cycles = 0;
    wait (rst_ni === 1'b1);
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    int tick_set [8];
    int mode_set [8];
    int target_items;
    sb = new();
    tick_set = '{1, 3, 0, 8, 2, 5, 1, 4};
    mode_set = '{0, 1, 0, 1, 1, 0, 1, 0};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    allow_lock     = 1'b0;
    items_sent     = 0;
    phases         = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ofpc_pkg::CMD_READ;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= ofpc_pkg::CFG_PROGRAM_TICKS;
    cfg_data_i    <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, read-only and write-only registers, refusals
    start_phase(16'd1, 1'b1, 0);
    send_access(ofpc_pkg::CMD_READ, '0, '0);
    send_access(ofpc_pkg::CMD_READ, LAST_WORD, '0);
    send_access(ofpc_pkg::CMD_READ, ofpc_pkg::ADDR_CONTROL, '0);
    send_access(ofpc_pkg::CMD_READ, ofpc_pkg::ADDR_BIT, '0);
    send_access(ofpc_pkg::CMD_WRITE, 8'd5, 32'hFFFF_FFFF);
    send_access(ofpc_pkg::CMD_READ, 8'd5, '0);
    send_access(ofpc_pkg::CMD_WRITE, ofpc_pkg::ADDR_CONTROL, 32'h7);
    send_access(ofpc_pkg::CMD_READ, ofpc_pkg::ADDR_PERFORM, '0);
    send_access(ofpc_pkg::CMD_READ, ofpc_pkg::ADDR_PAD_EN, '0);
    send_access(ofpc_pkg::CMD_READ, ofpc_pkg::ADDR_PAD, '0);
    send_access(ofpc_pkg::CMD_WRITE, ADDR_UNMAPPED, 32'hFFFF_FFFF);
    send_access(CMD_UNUSED, ADDR_UNMAPPED, 32'hFFFF_FFFF);
    send_access(ofpc_pkg::CMD_TICK, '0, '0);
    send_access(ofpc_pkg::CMD_WRITE, ofpc_pkg::ADDR_BIT, 32'hFFFF_FFFF);
    send_access(ofpc_pkg::CMD_READ, ofpc_pkg::ADDR_BIT, '0);
    arm_pads(1'b1);
    send_access(ofpc_pkg::CMD_WRITE, ofpc_pkg::ADDR_PERFORM, ofpc_pkg::MAGIC_PERFORM);
    send_access(ofpc_pkg::CMD_WRITE, ofpc_pkg::ADDR_BIT, FUSE_BITS);
    send_access(ofpc_pkg::CMD_WRITE, ofpc_pkg::ADDR_PERFORM, ofpc_pkg::MAGIC_PERFORM);
    send_access(ofpc_pkg::CMD_WRITE, ofpc_pkg::ADDR_BIT, FUSE_BITS - 1);
    send_access(ofpc_pkg::CMD_WRITE, ofpc_pkg::ADDR_PAD_EN, '0);
    send_access(ofpc_pkg::CMD_WRITE, ofpc_pkg::ADDR_PERFORM, ofpc_pkg::MAGIC_PERFORM);
    send_access(ofpc_pkg::CMD_WRITE, ofpc_pkg::ADDR_PAD_EN, ofpc_pkg::MAGIC_PAD_EN);
    send_access(ofpc_pkg::CMD_WRITE, ofpc_pkg::ADDR_PERFORM, '0);
    send_access(ofpc_pkg::CMD_WRITE, ofpc_pkg::ADDR_PERFORM, ofpc_pkg::MAGIC_PERFORM);
    send_access(ofpc_pkg::CMD_WRITE, ofpc_pkg::ADDR_BIT, '0);
    send_access(ofpc_pkg::CMD_WRITE, ofpc_pkg::ADDR_PERFORM, ofpc_pkg::MAGIC_PERFORM);
    send_access(ofpc_pkg::CMD_TICK, '0, '0);
    send_access(ofpc_pkg::CMD_READ, LAST_WORD, '0);

    // random phases over register settings and idle patterns
    for (int p = 0; p < 8; p++) begin
      start_phase(16'(tick_set[p]), mode_set[p][0], p % 4);
      target_items = items_sent + 30;
      while (items_sent < target_items) begin
        if ($urandom_range(9) < 6) run_program_sequence();
        else send_noise();
      end
    end

    // long programming time, then a full run to completion
    start_phase(16'(LONG_TICKS), 1'b0, 0);
    settle_busy();
    send_access(ofpc_pkg::CMD_WRITE, ofpc_pkg::ADDR_BIT, FUSE_BITS - 1);
    arm_pads(1'b1);
    send_access(ofpc_pkg::CMD_WRITE, ofpc_pkg::ADDR_PERFORM, ofpc_pkg::MAGIC_PERFORM);
    for (int i = 0; i < LONG_TICKS; i++) begin
      send_access(ofpc_pkg::CMD_TICK, $urandom, $urandom);
      if (i == 0 || i == LONG_TICKS - 2) begin
        send_access(ofpc_pkg::CMD_READ, ofpc_pkg::ADDR_CONTROL, '0);
      end
    end
    send_access(ofpc_pkg::CMD_READ, ofpc_pkg::ADDR_CONTROL, '0);
    send_access(ofpc_pkg::CMD_READ, LAST_WORD, '0);

    // program the lock fuse, then every further programming is refused
    start_phase(16'd2, 1'b1, 3);
    allow_lock = 1'b1;
    settle_busy();
    send_access(ofpc_pkg::CMD_WRITE, ofpc_pkg::ADDR_BIT, LOCK_BIT);
    arm_pads(1'b1);
    send_access(ofpc_pkg::CMD_WRITE, ofpc_pkg::ADDR_PERFORM, ofpc_pkg::MAGIC_PERFORM);
    send_access(ofpc_pkg::CMD_TICK, '0, '0);
    send_access(ofpc_pkg::CMD_TICK, '0, '0);
    send_access(ofpc_pkg::CMD_READ, LOCK_WORD, '0);
    send_access(ofpc_pkg::CMD_WRITE, ofpc_pkg::ADDR_BIT, 32'd7);
    send_access(ofpc_pkg::CMD_WRITE, ofpc_pkg::ADDR_PERFORM, ofpc_pkg::MAGIC_PERFORM);
    send_access(ofpc_pkg::CMD_READ, ofpc_pkg::ADDR_CONTROL, '0);
    target_items = items_sent + 30;
    while (items_sent < target_items) begin
      if ($urandom_range(1) == 0) run_program_sequence();
      else send_noise();
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("run: %0d accesses driven, %0d results compared, %0d register phases",
             items_sent, sb.checked, phases);
    $display("run: idle and stall patterns, programming times 0 to %0d ticks, test mode, lock fuse",
             LONG_TICKS);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
